[rtl/seven_segment_mux_driver_defines.svh]
// Assertion helpers for the seven-segment display driver.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SEVEN_SEGMENT_MUX_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_MUX_DRIVER_DEFINES_SVH

// The condition implies the consequence in the same cycle.
`define SSD_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// The condition implies the consequence in the following cycle.
`define SSD_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ssd_pkg.sv]
`timescale 1ns / 1ps
package ssd_pkg;

  // Default geometry and timing.
  localparam int DIGITS_DEF      = 4;
  localparam int SLOT_TICKS_DEF  = 6;
  localparam int BLINK_TICKS_DEF = 40;

  localparam int DIGIT_SEL_W = 2;
  localparam int PATTERN_W   = 8;
  localparam int BRIGHT_W    = 3;
  localparam int CFG_INDEX_W = 1;

  // Item kind codes as they arrive on the input channel.
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_TOGGLE = 2'd2;
  localparam logic [1:0] KIND_ERASE  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLANK      = 1'b1;

  localparam logic [BRIGHT_W-1:0]  BRIGHTNESS_RST = 3'd3;
  localparam logic [PATTERN_W-1:0] BLANK_RST      = 8'd0;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_TOGGLE,
    OP_ERASE
  } ssd_op_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [DIGIT_SEL_W-1:0] digit_index;
    logic [PATTERN_W-1:0]   char_value;
  } ssd_item_t;

  typedef struct packed {
    logic [PATTERN_W-1:0]   segments;
    logic [DIGIT_SEL_W-1:0] digit_select;
  } ssd_result_t;

  // Decoded command held in the queue between front and back.
  typedef struct packed {
    ssd_op_t                op;
    logic [DIGIT_SEL_W-1:0] digit_index;
    logic [PATTERN_W-1:0]   char_value;
  } ssd_cmd_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0]  brightness;
    logic [PATTERN_W-1:0] blank;
  } ssd_cfg_t;

endpackage

[rtl/seven_segment_mux_driver.sv]
// Multiplexed seven-segment display driver for up to four digits. Each input
// transaction is one of four kinds: a tick, a write of one digit's segment
// pattern, a blink toggle, or an erase that fills every digit with the blank
// pattern. Only a tick produces an output transaction, carrying the segment
// pins (the pattern of the digit that was active when the tick arrived, or
// the blank pattern while the digit is dark or the blink phase is off) and
// the digit select after any advance to the next digit. The block takes one
// transaction per clock cycle when the output side keeps up. An accepted tick
// is held in the command queue and is then loaded into the output register
// once that register is free or its result is being taken. The two-entry
// queue between the decode front and the execution back lets input keep
// flowing while a finished result waits to be taken.
// Configuration writes must only be issued while no transaction is in
// flight.
`timescale 1ns / 1ps
`include "seven_segment_mux_driver_defines.svh"
module seven_segment_mux_driver import ssd_pkg::*; #(
  parameter int DIGITS      = DIGITS_DEF,
  parameter int SLOT_TICKS  = SLOT_TICKS_DEF,
  parameter int BLINK_TICKS = BLINK_TICKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  ssd_item_t              item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output ssd_result_t            result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [PATTERN_W-1:0]   cfg_data
);

  // Configuration registers. Writes are always accepted.
  ssd_cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness <= BRIGHTNESS_RST;
      cfg.blank      <= BLANK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BRIGHTNESS: cfg.brightness <= cfg_data[BRIGHT_W-1:0];
        CFG_BLANK:      cfg.blank      <= cfg_data;
        default:        ;
      endcase
    end
  end

  // The front decodes each transaction and queues it; the back executes
  // queued commands and owns all display state and the output register.
  logic     cmd_valid;
  ssd_cmd_t cmd;
  logic     cmd_pop;

  ssd_front #(
    .DIGITS (DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  ssd_back #(
    .DIGITS      (DIGITS),
    .SLOT_TICKS  (SLOT_TICKS),
    .BLINK_TICKS (BLINK_TICKS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result       (result),
    .result_ready (result_ready)
  );

  // A tick must never be executed while the output register holds an untaken result.
  `SSD_ASSERT_NOW(a_no_tick_overwrite, cmd_valid && cmd.op == OP_TICK && result_valid && !result_ready, !cmd_pop, "tick executed over a pending result")

  // An executed tick is presented at the output on the next cycle.
  `SSD_ASSERT_NEXT(a_tick_gives_result, cmd_pop && cmd.op == OP_TICK, result_valid, "executed tick produced no result")

  // An accepted tick is held in the queue on the next cycle.
  `SSD_ASSERT_NEXT(a_tick_queued, item_valid && item_ready && item.kind == KIND_TICK, cmd_valid, "accepted tick was not queued")

  // The digit select never names a digit beyond the display.
  `SSD_ASSERT_NOW(a_select_range, result_valid, int'(result.digit_select) < DIGITS, "digit select out of range")

endmodule

[rtl/ssd_front.sv]
`timescale 1ns / 1ps
module ssd_front import ssd_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  ssd_item_t item,
  output logic      item_ready,
  output logic      cmd_valid,
  output ssd_cmd_t  cmd,
  input  logic      cmd_pop
);

  // Two-entry command queue.
  ssd_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  ssd_cmd_t decoded;
  logic     keep;
  logic     push;

  // Writes to a digit that does not exist are accepted and dropped here.
  always_comb begin
    decoded.digit_index = item.digit_index;
    decoded.char_value  = item.char_value;
    keep                = 1'b1;
    case (item.kind)
      KIND_TICK:   decoded.op = OP_TICK;
      KIND_WRITE: begin
        decoded.op = OP_WRITE;
        keep       = (int'(item.digit_index) < DIGITS);
      end
      KIND_TOGGLE: decoded.op = OP_TOGGLE;
      KIND_ERASE:  decoded.op = OP_ERASE;
      default:     decoded.op = OP_TICK;
    endcase
  end

  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready && keep;
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/ssd_back.sv]
`timescale 1ns / 1ps
module ssd_back import ssd_pkg::*; #(
  parameter int DIGITS      = DIGITS_DEF,
  parameter int SLOT_TICKS  = SLOT_TICKS_DEF,
  parameter int BLINK_TICKS = BLINK_TICKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ssd_cfg_t    cfg,
  input  logic        cmd_valid,
  input  ssd_cmd_t    cmd,
  output logic        cmd_pop,
  output logic        result_valid,
  output ssd_result_t result,
  input  logic        result_ready
);

  localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int SLOT_W = $clog2(SLOT_TICKS + 1);
  localparam int RELOAD_INT = (SLOT_TICKS * BLINK_TICKS > 255) ? 255 : SLOT_TICKS * BLINK_TICKS;
  localparam logic [7:0]        BLINK_RELOAD = 8'(RELOAD_INT);
  localparam logic [7:0]        BLINK_START  = 8'(BLINK_TICKS);
  localparam logic [SLOT_W-1:0] SLOT_FULL    = SLOT_W'(SLOT_TICKS);
  localparam logic [IDX_W-1:0]  LAST_DIGIT   = IDX_W'(DIGITS - 1);
  localparam logic signed [3:0] ON_MIN       = -4'sd8;

  logic [PATTERN_W-1:0] digit_store [DIGITS];
  logic [IDX_W-1:0]     active_digit;
  logic [SLOT_W-1:0]    slot_tick_count;
  logic signed [3:0]    on_time_left;
  logic                 blink_enabled;
  logic                 blink_phase_on;
  logic [7:0]           blink_count;

  logic [IDX_W-1:0]     active_digit_next;
  logic [SLOT_W-1:0]    slot_tick_count_next;
  logic signed [3:0]    on_time_left_next;
  logic                 blink_enabled_next;
  logic                 blink_phase_on_next;
  logic [7:0]           blink_count_next;
  logic [7:0]           blink_dec;
  logic [SLOT_W-1:0]    slot_dec;
  logic [PATTERN_W-1:0] seg_next;
  logic                 is_tick;

  assign is_tick = (cmd.op == OP_TICK);
  // A tick waits only when the output register is still full and not being taken.
  assign cmd_pop = cmd_valid && (!is_tick || !result_valid || result_ready);

  always_comb begin
    active_digit_next    = active_digit;
    slot_tick_count_next = slot_tick_count;
    on_time_left_next    = on_time_left;
    blink_enabled_next   = blink_enabled;
    blink_phase_on_next  = blink_phase_on;
    blink_count_next     = blink_count;
    blink_dec            = blink_count - 8'd1;
    slot_dec             = slot_tick_count - SLOT_W'(1);
    seg_next             = cfg.blank;
    case (cmd.op)
      OP_TOGGLE: begin
        blink_enabled_next = !blink_enabled;
        blink_count_next   = blink_enabled ? 8'd0 : BLINK_START;
      end
      OP_TICK: begin
        if (blink_enabled) begin
          if (blink_dec == 8'd0) begin
            blink_phase_on_next = !blink_phase_on;
            blink_count_next    = BLINK_RELOAD;
          end else begin
            blink_count_next = blink_dec;
          end
        end
        if (blink_phase_on_next && (on_time_left > 4'sd0)) begin
          seg_next = digit_store[active_digit];
        end
        if (on_time_left > ON_MIN) begin
          on_time_left_next = on_time_left - 4'sd1;
        end
        if (slot_dec == '0) begin
          on_time_left_next    = $signed({1'b0, cfg.brightness});
          slot_tick_count_next = SLOT_FULL;
          active_digit_next    = (active_digit == LAST_DIGIT) ? '0 : active_digit + IDX_W'(1);
        end else begin
          slot_tick_count_next = slot_dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) begin
        digit_store[i] <= '0;
      end
      active_digit    <= '0;
      slot_tick_count <= SLOT_FULL;
      on_time_left    <= 4'sd1;
      blink_enabled   <= 1'b0;
      blink_phase_on  <= 1'b1;
      blink_count     <= 8'd0;
      result_valid    <= 1'b0;
    end else begin
      if (cmd_pop) begin
        active_digit    <= active_digit_next;
        slot_tick_count <= slot_tick_count_next;
        on_time_left    <= on_time_left_next;
        blink_enabled   <= blink_enabled_next;
        blink_phase_on  <= blink_phase_on_next;
        blink_count     <= blink_count_next;
        if (cmd.op == OP_WRITE) begin
          digit_store[cmd.digit_index[IDX_W-1:0]] <= cmd.char_value;
        end
        if (cmd.op == OP_ERASE) begin
          for (int i = 0; i < DIGITS; i++) begin
            digit_store[i] <= cfg.blank;
          end
        end
      end
      if (cmd_pop && is_tick) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && is_tick) begin
      result.segments     <= seg_next;
      result.digit_select <= DIGIT_SEL_W'(active_digit_next);
    end
  end

endmodule
